FILE: design/double_ended_queue_defines.svh
// Assertion macros for the double-ended queue.
// Used by the top level only; relies on clk and arst_n being in scope.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

FILE: design/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; imported by every module of the block.
package deq_pkg;

	localparam int DEPTH_DEF = 64;

	typedef logic signed [31:0] data_t;

	typedef enum logic [2:0] {
		OP_ADD_FRONT = 3'd0,
		OP_ADD_REAR  = 3'd1,
		OP_DEL_FRONT = 3'd2,
		OP_DEL_REAR  = 3'd3,
		OP_DUMP      = 3'd4
	} op_e;

	typedef enum logic [2:0] {
		KIND_DONE  = 3'd0,
		KIND_ELEM  = 3'd1,
		KIND_EMPTY = 3'd2,
		KIND_UNDER = 3'd3,
		KIND_OVER  = 3'd4
	} kind_e;

	typedef struct packed {
		logic [2:0] op;
		data_t      value;
	} req_t;

	typedef struct packed {
		data_t      element;
		logic [2:0] kind;
		logic       last;
	} rsp_t;

	// Command broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUT_REAR,
		CELL_POP_FRONT,
		CELL_ROTATE
	} cell_op_e;

	typedef struct packed {
		cell_op_e op;
		data_t    value;
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_e;

endpackage

FILE: design/deq_cell.sv
// One storage cell of the deque chain; cell 0 holds the front element.
// Depends on deq_pkg.
module deq_cell import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int OCC_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [OCC_W-1:0] occ,
	input  data_t            left,
	input  data_t            right,
	input  data_t            head,
	output data_t            data
);

	data_t data_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_PUSH_FRONT: data_q <= left;
			CELL_PUT_REAR: begin
				if (occ == OCC_W'(IDX)) begin
					data_q <= cmd.value;
				end
			end
			CELL_POP_FRONT: data_q <= right;
			// The rear occupied cell takes the front element, so the ring closes.
			CELL_ROTATE: data_q <= (occ == OCC_W'(IDX + 1)) ? head : right;
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

FILE: design/deq_ctrl.sv
// Sequencer of the deque: occupancy count, dump walk and result register.
// Depends on deq_pkg; drives the command shared by all cells.
module deq_ctrl import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int OCC_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  data_t            head,
	output cell_cmd_t        cell_cmd,
	output logic [OCC_W-1:0] occ
);

	state_e           state_q, state_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic [OCC_W-1:0] cnt_q, cnt_d;
	logic             rsp_valid_q;
	rsp_t             rsp_q, rsp_d;
	logic             load;
	logic             out_free;
	logic             accept;
	logic             full;
	logic             empty;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign full      = (occ_q == OCC_W'(DEPTH));
	assign empty     = (occ_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			cnt_q   <= cnt_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		occ_d          = occ_q;
		cnt_d          = cnt_q;
		load           = 1'b0;
		rsp_d.element  = '0;
		rsp_d.kind     = KIND_DONE;
		rsp_d.last     = 1'b1;
		cell_cmd.op    = CELL_HOLD;
		cell_cmd.value = req.value;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					load = 1'b1;
					unique case (req.op)
						OP_ADD_FRONT, OP_ADD_REAR: begin
							if (full) begin
								rsp_d.kind = KIND_OVER;
							end else begin
								cell_cmd.op = (req.op == OP_ADD_FRONT) ?
									CELL_PUSH_FRONT : CELL_PUT_REAR;
								occ_d = occ_q + OCC_W'(1);
							end
						end
						OP_DEL_FRONT, OP_DEL_REAR: begin
							if (empty) begin
								rsp_d.kind = KIND_UNDER;
							end else begin
								if (req.op == OP_DEL_FRONT) begin
									cell_cmd.op = CELL_POP_FRONT;
								end
								occ_d = occ_q - OCC_W'(1);
							end
						end
						OP_DUMP: begin
							if (empty) begin
								rsp_d.kind = KIND_EMPTY;
							end else begin
								// The first element is taken from the head in the cycle of acceptance.
								rsp_d.element = head;
								rsp_d.kind    = KIND_ELEM;
								rsp_d.last    = (occ_q == OCC_W'(1));
								cell_cmd.op   = CELL_ROTATE;
								if (occ_q != OCC_W'(1)) begin
									state_d = ST_DUMP;
									cnt_d   = OCC_W'(1);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					load          = 1'b1;
					rsp_d.element = head;
					rsp_d.kind    = KIND_ELEM;
					rsp_d.last    = (cnt_q + OCC_W'(1) == occ_q);
					cell_cmd.op   = CELL_ROTATE;
					cnt_d         = cnt_q + OCC_W'(1);
					if (cnt_q + OCC_W'(1) == occ_q) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign occ       = occ_q;

endmodule

FILE: design/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values, held in a chain of cells.
// Request channel (req_valid, req_stall, req): one item carries an operation:
// add at front or rear, remove from front or rear, or dump the contents.
// Response channel (rsp_valid, rsp_stall, rsp): a dump gives one item per
// stored element, front first, with last set on the final one, or a single
// empty item if nothing is stored; any other request gives one status item.
// Every result is registered: a status item or a dump's first item appears
// the cycle after its request is taken. Adds and removes go at one item per
// cycle while the response side keeps up. A dump returns its elements as the
// cell chain rotates by one place per cycle unless rsp_stall holds it; the
// requests stall until the dump is over. The chain ends where it started.
// Reset empties the queue at once; the cell contents are not cleared.
// While rsp_stall is high, a pending result holds and new requests stall.
`include "double_ended_queue_defines.svh"

module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int OCC_W = $clog2(DEPTH + 1);

	cell_cmd_t        cell_cmd;
	logic [OCC_W-1:0] occ;
	data_t            cell_data [DEPTH];

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.head     (cell_data[0]),
		.cell_cmd (cell_cmd),
		.occ      (occ)
	);

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		data_t left_data;
		data_t right_data;

		if (g == 0) begin : g_first
			assign left_data = cell_cmd.value;
		end else begin : g_inner_left
			assign left_data = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_data = cell_data[g];
		end else begin : g_inner_right
			assign right_data = cell_data[g+1];
		end

		deq_cell #(
			.DEPTH(DEPTH),
			.IDX  (g)
		) u_cell (
			.clk  (clk),
			.cmd  (cell_cmd),
			.occ  (occ),
			.left (left_data),
			.right(right_data),
			.head (cell_data[0]),
			.data (cell_data[g])
		);
	end

	`DEQ_ASSERT_NEXT(a_full_add_keeps_occ, req_valid && !req_stall && (req.op == OP_ADD_FRONT || req.op == OP_ADD_REAR) && occ == OCC_W'(DEPTH), $stable(occ))
	`DEQ_ASSERT_NEXT(a_empty_del_underflow, req_valid && !req_stall && (req.op == OP_DEL_FRONT || req.op == OP_DEL_REAR) && occ == '0, rsp_valid && rsp.kind == KIND_UNDER)
	`DEQ_ASSERT_SAME(a_rotate_not_empty, cell_cmd.op == CELL_ROTATE, occ != '0)

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed and random operations,
// with a queue-based prediction of the contents. Depends on deq_pkg and the block.
module tb;
	import deq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam data_t VAL_MAX = 32'sh7FFF_FFFF;
	localparam data_t VAL_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Contents of the deque as it should be, front first.
	data_t deque_contents[$];
	rsp_t pending_rsp_q[$];

	bit idle_on = 1'b1;
	int hold_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int mismatch_cnt = 0;
	int n_req = 0;
	int n_rsp = 0;
	int n_dump = 0;
	int n_over = 0;
	int n_under = 0;
	int longest_dump = 0;

	double_ended_queue #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	function automatic void push_status(input kind_e k);
		pending_rsp_q.push_back(rsp_t'{element: '0, kind: k, last: 1'b1});
	endfunction

	// Works out the results of one accepted item and updates the contents.
	function automatic void predict_deque_op(input req_t r);
		int n;
		n = deque_contents.size();
		case (r.op)
			OP_ADD_FRONT, OP_ADD_REAR: begin
				if (n >= DEPTH) begin
					push_status(KIND_OVER);
					n_over++;
				end else begin
					if (r.op == OP_ADD_FRONT)
						deque_contents.push_front(r.value);
					else
						deque_contents.push_back(r.value);
					push_status(KIND_DONE);
				end
			end
			OP_DEL_FRONT, OP_DEL_REAR: begin
				if (n == 0) begin
					push_status(KIND_UNDER);
					n_under++;
				end else begin
					if (r.op == OP_DEL_FRONT)
						void'(deque_contents.pop_front());
					else
						void'(deque_contents.pop_back());
					push_status(KIND_DONE);
				end
			end
			OP_DUMP: begin
				n_dump++;
				if (n == 0) begin
					push_status(KIND_EMPTY);
				end else begin
					if (n > longest_dump)
						longest_dump = n;
					for (int i = 0; i < n; i++)
						pending_rsp_q.push_back(rsp_t'{element: deque_contents[i],
							kind: KIND_ELEM, last: (i == n - 1)});
				end
			end
			default: push_status(KIND_DONE);
		endcase
	endfunction

	function automatic void check_response(input rsp_t got);
		rsp_t want;
		n_rsp++;
		if (pending_rsp_q.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("%0t: unexpected result element=%0d kind=%0d last=%0b",
					$realtime, got.element, got.kind, got.last);
			return;
		end
		want = pending_rsp_q.pop_front();
		if (got.element !== want.element || got.kind !== want.kind ||
				got.last !== want.last) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("%0t: mismatch: expected element=%0d kind=%0d last=%0b, %s%0d %s%0d %s%0b",
					$realtime, want.element, want.kind, want.last,
					"got element=", got.element, "kind=", got.kind, "last=", got.last);
		end
	endfunction

	// Both sides are sampled at the clock edge, before any driven change lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_deque_op(req);
				n_req++;
			end
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: a long hold-off when asked for, otherwise short random stalls.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Offers one item and returns at the edge where it is taken or after a gap.
	// Valid is only lowered for such a gap, so back-to-back items keep it high.
	task automatic send_item(input logic [2:0] op, input data_t v);
		req_valid <= 1'b1;
		req <= req_t'{op: op, value: v};
		do
			@(posedge clk);
		while (req_stall);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return -1;
			default: return data_t'($urandom);
		endcase
	endfunction

	task automatic send_random_item(input int add_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), pick_value());
		else if (r < 12)
			send_item(OP_DUMP, pick_value());
		else if (r < 12 + add_weight)
			send_item($urandom_range(0, 1) ? OP_ADD_FRONT : OP_ADD_REAR, pick_value());
		else
			send_item($urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_REAR, pick_value());
	endtask

	task automatic test_directed();
		send_item(OP_DUMP, '0);
		send_item(OP_DEL_FRONT, '0);
		send_item(OP_DEL_REAR, -1);
		send_item(OP_ADD_FRONT, VAL_MAX);
		send_item(OP_ADD_REAR, VAL_MIN);
		send_item(OP_ADD_FRONT, -1);
		send_item(OP_ADD_REAR, '0);
		send_item(OP_DUMP, '0);
		for (logic [3:0] op = 4'(OP_SPARE_LO); op <= 4'(OP_SPARE_HI); op++)
			send_item(op[2:0], pick_value());
		send_item(OP_DEL_FRONT, '0);
		send_item(OP_DEL_REAR, '0);
		send_item(OP_DUMP, '0);
		send_item(OP_DEL_REAR, '0);
		// A single element must carry last on its only dump result.
		send_item(OP_DUMP, '0);
		send_item(OP_DEL_FRONT, '0);
		send_item(OP_DEL_FRONT, '0);
		send_item(OP_ADD_REAR, 32'sh5555_5555);
		send_item(OP_ADD_FRONT, 32'shAAAA_AAAA);
		send_item(OP_DUMP, '0);
		send_item(OP_DEL_REAR, '0);
		send_item(OP_DEL_REAR, '0);
		send_item(OP_DUMP, '0);
	endtask

	// The directed part leaves the deque empty, so DEPTH adds fill it.
	task automatic test_full_and_overflow();
		for (int i = 0; i < DEPTH; i++)
			send_item($urandom_range(0, 1) ? OP_ADD_FRONT : OP_ADD_REAR, pick_value());
		send_item(OP_ADD_FRONT, pick_value());
		send_item(OP_ADD_REAR, pick_value());
		send_item(OP_DUMP, '0);
	endtask

	task automatic test_random_mix();
		// Drift towards empty first, then back towards full.
		for (int i = 0; i < 45; i++)
			send_random_item(25);
		for (int i = 0; i < 45; i++)
			send_random_item(60);
	endtask

	task automatic test_backpressure();
		hold_left = HOLD_OFF_CYCLES;
		for (int i = 0; i < 30; i++) begin
			if (i % 10 == 9)
				send_item(OP_DUMP, '0);
			else if (i % 3 == 2)
				send_item(OP_DEL_FRONT, '0);
			else
				send_item(OP_ADD_REAR, pick_value());
		end
	endtask

	task automatic test_calm_finish();
		idle_on = 1'b0;
		for (int i = 0; i < 20; i++)
			send_random_item(45);
		send_item(OP_DUMP, '0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_and_overflow();
		test_random_mix();
		test_backpressure();
		test_calm_finish();
		req_valid <= 1'b0;

		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d operations and %0d results, with %0d overflows and %0d underflows.",
			n_req, n_rsp, n_over, n_under);
		$display("Dumped %0d times, the longest dump being %0d elements; %0d mismatches.",
			n_dump, longest_dump, mismatch_cnt);
		if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/deq_pkg.sv
design/deq_cell.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
dv/tb.sv
